// ===== src/rx_fifo_packet_splitter_defines.svh =====
// Assertion helpers shared by the splitter modules.
`ifndef RX_FIFO_PACKET_SPLITTER_DEFINES_SVH
`define RX_FIFO_PACKET_SPLITTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RFPS_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
    (ante) |-> (cons)) else $error("rfps: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RFPS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) \
    (ante) |=> (cons)) else $error("rfps: next-cycle check failed");

`endif

// ===== src/rfps_pkg.sv =====
`default_nettype none
package rfps_pkg;

  // Bytes that follow the payload plus the length byte itself
  localparam logic [7:0] OVERHEAD = 8'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_RSSI    = 3'd3,
    PH_STATUS  = 3'd4,
    PH_DISCARD = 3'd5
  } rfps_phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_BAD_LEN = 2'd2
  } rfps_kind_t;

  typedef struct packed {
    rfps_kind_t         kind;
    logic [7:0]         payload_byte;
    logic signed [7:0]  signal_strength;
    logic [6:0]         link_quality;
    logic               crc_good;
    logic [7:0]         packet_length;
  } rfps_result_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       read_start;
    logic [7:0] read_length;
  } rfps_request_t;

endpackage
`default_nettype wire

// ===== src/rfps_parser.sv =====
`default_nettype none
`include "rx_fifo_packet_splitter_defines.svh"
module rfps_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire rfps_pkg::rfps_request_t req,
  output logic                      res_valid,
  output rfps_pkg::rfps_result_t    res
);
  import rfps_pkg::*;

  rfps_phase_t phase_r, phase_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  pay_rem_r, pay_rem_nxt;
  logic [7:0]  cur_len_r, cur_len_nxt;
  logic [7:0]  rssi_r, rssi_nxt;

  // Decode one byte against the parse state
  always_comb begin
    rfps_phase_t ph;
    logic [7:0]  r;
    ph          = req.read_start ? PH_LEN : phase_r;
    r           = req.read_start ? req.read_length : rem_r;
    phase_nxt   = ph;
    rem_nxt     = r;
    pay_rem_nxt = pay_rem_r;
    cur_len_nxt = cur_len_r;
    rssi_nxt    = rssi_r;
    res_valid   = 1'b0;
    res         = '0;
    res.kind    = KIND_PAYLOAD;

    if (ph == PH_IDLE || r == 8'd0) begin
      phase_nxt = PH_IDLE;
    end else begin
      unique case (ph)
        PH_LEN: begin
          if (r < OVERHEAD) begin
            phase_nxt = PH_DISCARD;
          end else if (req.rx_byte > r - OVERHEAD) begin
            res_valid         = acc;
            res.kind          = KIND_BAD_LEN;
            res.packet_length = req.rx_byte;
            phase_nxt         = PH_DISCARD;
          end else if (req.rx_byte == 8'd0) begin
            cur_len_nxt = 8'd0;
            phase_nxt   = PH_RSSI;
          end else begin
            cur_len_nxt = req.rx_byte;
            pay_rem_nxt = req.rx_byte;
            phase_nxt   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_valid         = acc;
          res.kind          = KIND_PAYLOAD;
          res.payload_byte  = req.rx_byte;
          res.packet_length = cur_len_r;
          pay_rem_nxt       = pay_rem_r - {7'd0, (pay_rem_r != 8'd0)};
          if (pay_rem_r <= 8'd1) begin
            phase_nxt = PH_RSSI;
          end
        end
        PH_RSSI: begin
          rssi_nxt  = req.rx_byte;
          phase_nxt = PH_STATUS;
        end
        PH_STATUS: begin
          if (cur_len_r != 8'd0) begin
            res_valid           = acc;
            res.kind            = KIND_END;
            res.signal_strength = rssi_r;
            res.link_quality    = req.rx_byte[6:0];
            res.crc_good        = req.rx_byte[7];
            res.packet_length   = cur_len_r;
          end
          phase_nxt = PH_LEN;
        end
        PH_DISCARD: begin
          phase_nxt = PH_DISCARD;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      // Consume the byte; end of read drops back to idle
      rem_nxt = r - 8'd1;
      if (rem_nxt == 8'd0) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // Advance the parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      rem_r     <= 8'd0;
      pay_rem_r <= 8'd0;
      cur_len_r <= 8'd0;
      rssi_r    <= 8'd0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      pay_rem_r <= pay_rem_nxt;
      cur_len_r <= cur_len_nxt;
      rssi_r    <= rssi_nxt;
    end
  end

  `RFPS_ASSERT_SAME(a_res_needs_acc, clk, rst_n, res_valid, acc)
  `RFPS_ASSERT_NEXT(a_bad_len_discards, clk, rst_n, res_valid && res.kind == KIND_BAD_LEN,
                    phase_r == PH_DISCARD || phase_r == PH_IDLE)
  `RFPS_ASSERT_SAME(a_payload_count_live, clk, rst_n, phase_r == PH_PAYLOAD,
                    pay_rem_r != 8'd0)

endmodule
`default_nettype wire

// ===== src/rx_fifo_packet_splitter.sv =====
`default_nettype none
`include "rx_fifo_packet_splitter_defines.svh"
// Receive-FIFO packet splitter. Takes one byte of a FIFO read per cycle
// while in_stall is low (in_read_start flags the first byte and carries the
// read length) and splits length-prefixed packets: each payload byte comes
// out as a payload request, the status byte of a non-empty packet as a
// packet-end request with RSSI, LQI and CRC flag (crc_good low means drop
// the packet), and a length that does not fit the rest of the read as an
// error request after which the read is discarded. Each result is registered
// in the output register, or in a one-entry skid register while out_stall
// holds it; the two absorb a stall, so in_stall rises only when both are full.
module rx_fifo_packet_splitter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_rx_byte,
  input  wire logic              in_read_start,
  input  wire logic [7:0]        in_read_length,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_result_kind,
  output logic [7:0]             out_payload_byte,
  output logic signed [7:0]      out_signal_strength,
  output logic [6:0]             out_link_quality,
  output logic                   out_crc_good,
  output logic [7:0]             out_packet_length
);
  import rfps_pkg::*;

  logic          acc;
  rfps_request_t req;
  logic          new_valid;
  rfps_result_t  new_res;
  logic          out_valid_r, skid_valid_r;
  rfps_result_t  out_r, skid_r;
  logic          drain;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;
  assign req      = '{rx_byte: in_rx_byte, read_start: in_read_start,
                      read_length: in_read_length};

  rfps_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (req),
    .res_valid (new_valid),
    .res       (new_res)
  );

  assign drain = !out_valid_r || !out_stall;

  // Hold or advance the output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= new_valid;
      end
    end else if (new_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves with the valid bits, no reset
  always_ff @(posedge clk) begin
    if (drain) begin
      out_r <= skid_valid_r ? skid_r : new_res;
    end else if (new_valid) begin
      skid_r <= new_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_r.kind;
  assign out_payload_byte    = out_r.payload_byte;
  assign out_signal_strength = out_r.signal_strength;
  assign out_link_quality    = out_r.link_quality;
  assign out_crc_good        = out_r.crc_good;
  assign out_packet_length   = out_r.packet_length;

  `RFPS_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `RFPS_ASSERT_NEXT(a_skid_refills_out, clk, rst_n, skid_valid_r && !out_stall,
                    out_valid_r)
  `RFPS_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_r && out_stall,
                    out_valid_r && $stable(out_r))

endmodule
`default_nettype wire
